// File: sv/twcs_pkg.sv
package twcs_pkg;

    localparam int unsigned COORD_W   = 11;
    localparam int unsigned TEXEL_W   = 10;
    localparam int unsigned LINE_W    = 16;
    localparam int unsigned POS_W     = 24;
    localparam int unsigned DIR_W     = 18;
    localparam int unsigned LOG2_W    = 4;
    localparam int unsigned FIX_W     = 32;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_WIDTH       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_HEIGHT_LOG2 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT       = 2'd2;

    localparam logic [COORD_W-1:0] TEXTURE_WIDTH_RST       = 11'd64;
    localparam logic [LOG2_W-1:0]  TEXTURE_HEIGHT_LOG2_RST = 4'd6;
    localparam logic [COORD_W-1:0] WINDOW_HEIGHT_RST       = 11'd600;

    localparam logic ACTION_START = 1'b0;
    localparam logic ACTION_PIXEL = 1'b1;

endpackage

// File: sv/textured_wall_column_span.sv
// a pixel request shows its result on the output register in the cycle after acceptance
// throughput: pixel requests are taken one per cycle while the output is not stalled and no column setup runs
// a column-start request stalls the input through column setup: the shared multiplier in
// ST_HIT (hit coordinate), then in ST_SCALE (texture column), then the row step divider
// reset (rst_n low, asynchronous) restores configuration register defaults and leaves no span active
module textured_wall_column_span
    import twcs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DAT_W-1:0]    cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    action,
    input  logic [COORD_W-1:0]      column_x,
    input  logic [COORD_W-1:0]      span_start,
    input  logic [COORD_W-1:0]      span_end,
    input  logic [LINE_W-1:0]       wall_line_height,
    input  logic                    hit_side,
    input  logic [POS_W-1:0]        wall_distance,
    input  logic signed [DIR_W-1:0] ray_x,
    input  logic signed [DIR_W-1:0] ray_y,
    input  logic [POS_W-1:0]        viewer_x,
    input  logic [POS_W-1:0]        viewer_y,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [COORD_W-1:0]      pixel_x,
    output logic [COORD_W-1:0]      pixel_y,
    output logic [TEXEL_W-1:0]      texel_u,
    output logic [TEXEL_W-1:0]      texel_v,
    output logic                    final_pixel
);

    localparam int unsigned MUL_A_W = POS_W + 1;
    localparam int unsigned MUL_P_W = MUL_A_W + DIR_W;
    localparam int unsigned OFS_W   = LINE_W + 1;
    localparam int unsigned CNT_W   = $clog2(FIX_W);
    localparam int unsigned FRAC_W  = FIX_W / 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HIT,
        ST_SCALE,
        ST_DIV
    } state_t;

    state_t                    state_reg;
    logic [CNT_W-1:0]          div_cnt_reg;

    logic [COORD_W-1:0]        tex_width_reg;
    logic [LOG2_W-1:0]         tex_log2_reg;
    logic [COORD_W-1:0]        view_rows_reg;

    logic [COORD_W-1:0]        held_column_reg;
    logic [COORD_W-1:0]        current_row_reg;
    logic [COORD_W-1:0]        stop_row_reg;
    logic [TEXEL_W-1:0]        held_texel_u_reg;
    logic [FIX_W-1:0]          row_acc_reg;
    logic [FIX_W-1:0]          row_step_reg;

    logic [POS_W-1:0]          dist_reg;
    logic signed [DIR_W-1:0]   dir_reg;
    logic [FRAC_W-1:0]         pos_lo_reg;
    logic                      mirror_reg;
    logic [LINE_W-1:0]         divisor_reg;
    logic signed [OFS_W-1:0]   offset_reg;
    logic [FIX_W-1:0]          dividend_reg;
    logic [LINE_W-1:0]         rem_reg;
    logic signed [MUL_P_W-1:0] prod_reg;

    logic                      out_valid_reg;
    logic [COORD_W-1:0]        pixel_x_reg;
    logic [COORD_W-1:0]        pixel_y_reg;
    logic [TEXEL_W-1:0]        texel_u_reg;
    logic [TEXEL_W-1:0]        texel_v_reg;
    logic                      final_pixel_reg;

    logic                      in_accept;
    logic                      span_active;
    logic                      emit;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [DIR_W-1:0]   mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic [FRAC_W-1:0]         hit_frac;
    logic [TEXEL_W-1:0]        u_plain;
    logic [TEXEL_W-1:0]        u_final;
    logic [LINE_W:0]           rem_shift;
    logic                      q_bit;
    logic [LINE_W-1:0]         rem_next;
    logic [FIX_W-1:0]          acc_add;
    logic [FIX_W-1:0]          row_acc_next;
    logic [FRAC_W-1:0]         row_mask;
    logic [FRAC_W-1:0]         row_bits;
    logic signed [OFS_W-1:0]   offset_in;
    logic [LINE_W-1:0]         divisor_in;

    assign in_stall    = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign in_accept   = in_valid && !in_stall;
    assign span_active = current_row_reg < stop_row_reg;
    assign emit        = in_accept && (action == ACTION_PIXEL) && span_active;

    // shared multiplier: distance * direction, then fraction * texture width
    always_comb
    begin
        if (state_reg == ST_SCALE)
        begin
            mul_a = $signed({{(MUL_A_W-FRAC_W){1'b0}}, hit_frac});
            mul_b = $signed({{(DIR_W-COORD_W){1'b0}}, tex_width_reg});
        end
        else
        begin
            mul_a = $signed({1'b0, dist_reg});
            mul_b = dir_reg;
        end
        mul_p = mul_a * mul_b;
    end

    assign hit_frac = pos_lo_reg + prod_reg[FIX_W-1:FRAC_W];
    assign u_plain  = prod_reg[FRAC_W+TEXEL_W-1:FRAC_W];
    assign u_final  = mirror_reg ? (tex_width_reg[TEXEL_W-1:0] - u_plain - 1'b1) : u_plain;

    // restoring divide step, quotient bits also fold the offset product into the accumulator
    assign rem_shift    = {rem_reg, dividend_reg[FIX_W-1]};
    assign q_bit        = rem_shift >= {1'b0, divisor_reg};
    assign rem_next     = q_bit ? LINE_W'(rem_shift - {1'b0, divisor_reg})
                                : rem_shift[LINE_W-1:0];
    assign acc_add      = q_bit ? FIX_W'(offset_reg) : '0;
    assign row_acc_next = {row_acc_reg[FIX_W-2:0], 1'b0} + acc_add;

    assign offset_in  = $signed({{(OFS_W-COORD_W){1'b0}}, span_start})
                      - $signed({{(OFS_W-COORD_W+1){1'b0}}, view_rows_reg[COORD_W-1:1]})
                      + $signed({2'b00, wall_line_height[LINE_W-1:1]});
    assign divisor_in = (wall_line_height == '0) ? LINE_W'(1) : wall_line_height;

    assign row_mask = ~({FRAC_W{1'b1}} << tex_log2_reg);
    assign row_bits = row_acc_reg[FIX_W-1:FRAC_W] & row_mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            div_cnt_reg      <= '0;
            tex_width_reg    <= TEXTURE_WIDTH_RST;
            tex_log2_reg     <= TEXTURE_HEIGHT_LOG2_RST;
            view_rows_reg    <= WINDOW_HEIGHT_RST;
            held_column_reg  <= '0;
            current_row_reg  <= '0;
            stop_row_reg     <= '0;
            held_texel_u_reg <= '0;
            row_acc_reg      <= '0;
            row_step_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TEXTURE_WIDTH:       tex_width_reg  <= cfg_data;
                    REG_TEXTURE_HEIGHT_LOG2: tex_log2_reg   <= cfg_data[LOG2_W-1:0];
                    REG_WINDOW_HEIGHT:       view_rows_reg  <= cfg_data;
                    default:                 ;
                endcase
            end

            if (emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept && (action == ACTION_START))
                    begin
                        held_column_reg <= column_x;
                        current_row_reg <= span_start;
                        stop_row_reg    <= span_end;
                        row_acc_reg     <= '0;
                        row_step_reg    <= '0;
                        state_reg       <= ST_HIT;
                    end
                    else if (emit)
                    begin
                        row_acc_reg     <= row_acc_reg + row_step_reg;
                        current_row_reg <= current_row_reg + 1'b1;
                    end
                end
                ST_HIT:
                begin
                    state_reg <= ST_SCALE;
                end
                ST_SCALE:
                begin
                    div_cnt_reg <= '0;
                    state_reg   <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_cnt_reg == '0)
                        held_texel_u_reg <= u_final;
                    row_step_reg <= {row_step_reg[FIX_W-2:0], q_bit};
                    row_acc_reg  <= row_acc_next;
                    div_cnt_reg  <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == CNT_W'(FIX_W - 1))
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath scratch, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept && (action == ACTION_START) && (state_reg == ST_IDLE))
        begin
            dist_reg     <= wall_distance;
            dir_reg      <= hit_side ? ray_x : ray_y;
            pos_lo_reg   <= hit_side ? viewer_x[FRAC_W-1:0] : viewer_y[FRAC_W-1:0];
            mirror_reg   <= hit_side ? ray_y[DIR_W-1] : ray_x[DIR_W-1];
            divisor_reg  <= divisor_in;
            offset_reg   <= offset_in;
            dividend_reg <= FIX_W'(1) << (tex_log2_reg + 5'd16);
            rem_reg      <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            dividend_reg <= {dividend_reg[FIX_W-2:0], 1'b0};
            rem_reg      <= rem_next;
        end

        if ((state_reg == ST_HIT) || (state_reg == ST_SCALE))
            prod_reg <= mul_p;

        if (emit)
        begin
            pixel_x_reg     <= held_column_reg;
            pixel_y_reg     <= current_row_reg;
            texel_u_reg     <= held_texel_u_reg;
            texel_v_reg     <= row_bits[TEXEL_W-1:0];
            final_pixel_reg <= (current_row_reg + 1'b1) == stop_row_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign texel_u     = texel_u_reg;
    assign texel_v     = texel_v_reg;
    assign final_pixel = final_pixel_reg;

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("request accepted while column setup in progress");

    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) && (div_cnt_reg == CNT_W'(FIX_W - 1)) |=> (state_reg == ST_IDLE))
        else $error("divider did not finish after full iteration count");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid && (pixel_y == $past(current_row_reg)))
        else $error("pixel request did not produce its result");

    a_row_advance: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (current_row_reg == $past(current_row_reg) + 1'b1))
        else $error("row counter did not advance on emitted pixel");

endmodule
